// File: design/event_voxel_grid_accumulator_defines.svh
// Assertion macros for the event voxel grid accumulator.
`ifndef EVENT_VOXEL_GRID_ACCUMULATOR_DEFINES_SVH
`define EVENT_VOXEL_GRID_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every clock edge outside reset.
`define EVGA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication, checked at every clock edge outside reset.
`define EVGA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define EVGA_ASSERT_IMPL(lbl, ante, cons)
`define EVGA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: design/evga_pkg.sv
// Shared constants, types and helpers of the event voxel grid accumulator.
package evga_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int MAX_BINS   = 8;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int BIN_W  = $clog2(MAX_BINS);
  localparam int CELL_COUNT = MAX_BINS * MAX_HEIGHT * MAX_WIDTH;
  localparam int ADDR_W = $clog2(CELL_COUNT);

  localparam int CELL_W = 32;
  localparam int PADDR_W = 4;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_SENSOR_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SENSOR_HEIGHT = 2'd1;
  localparam logic [1:0] REG_NUM_BINS      = 2'd2;
  localparam logic [1:0] REG_BINS_PER_US   = 2'd3;

  // Command codes
  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic [9:0]  sensor_width;
    logic [9:0]  sensor_height;
    logic [3:0]  num_bins;
    logic [23:0] bins_per_us;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDOUT,
    ST_TIME,
    ST_NBR,
    ST_MUL,
    ST_WR
  } state_e;

  // Linear cell address: bin-major, then row, then column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [BIN_W-1:0] bin,
                                                   input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(bin) * ADDR_W'(MAX_HEIGHT * MAX_WIDTH)
      + ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
    return a;
  endfunction

endpackage

// File: design/evga_ram.sv
// Generic simple dual-port RAM with registered read.
module evga_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds the last word read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/evga_core.sv
// Sequencer and datapath: clearing pass, cell read-and-clear, trilinear splat.
module evga_core
  import evga_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              start_i,
  input  logic              command_i,
  input  logic signed [19:0] x_pos_i,
  input  logic signed [19:0] y_pos_i,
  input  logic [31:0]       timestamp_us_i,
  input  logic              polarity_i,
  input  logic              frame_start_i,
  input  logic [2:0]        cell_bin_i,
  input  logic [8:0]        cell_row_i,
  input  logic [8:0]        cell_col_i,
  output logic              busy_o,
  output logic              voxel_valid_o,
  output logic signed [31:0] voxel_value_o
);

  state_e state_q, state_d;

  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [31:0]       ws_q, ws_d;
  logic [31:0]       dt_q, dt_d;
  logic [31:0]       t0_q, t0_d;
  logic [23:0]       ft_q, ft_d;
  logic [2:0]        nbr_q, nbr_d;
  logic              neg_q, neg_d;
  logic signed [11:0] x0_q, x0_d, y0_q, y0_d;
  logic [7:0]        fx_q, fx_d, fy_q, fy_d;
  logic [16:0]       wxy_q, wxy_d;
  logic [41:0]       prod_q, prod_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              rd_ok_q, rd_ok_d;
  logic              valid_q, valid_d;
  logic [31:0]       value_q, value_d;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic              accept;
  logic              last_nbr;
  logic [9:0]        w_eff, h_eff;
  logic [3:0]        n_eff;
  logic signed [12:0] col, row;
  logic [32:0]       bin;
  logic              nbr_ok;
  logic [8:0]        wx, wy;
  logic [24:0]       wt;
  logic [41:0]       rnd;
  logic [17:0]       mag;
  logic signed [32:0] delta, sum;
  logic [31:0]       sat;
  logic [55:0]       p;
  logic              in_store;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign busy_o   = (state_q != ST_IDLE);
  assign last_nbr = (nbr_q == 3'd7);

  // Effective grid size
  assign w_eff = (32'(cfg_i.sensor_width)  < MAX_WIDTH)  ? cfg_i.sensor_width
                                                          : 10'(MAX_WIDTH);
  assign h_eff = (32'(cfg_i.sensor_height) < MAX_HEIGHT) ? cfg_i.sensor_height
                                                          : 10'(MAX_HEIGHT);
  assign n_eff = (32'(cfg_i.num_bins) < MAX_BINS) ? cfg_i.num_bins : 4'(MAX_BINS);

  // Neighbor coordinates and range check
  assign col    = 13'(x0_q) + 13'(nbr_q[2]);
  assign row    = 13'(y0_q) + 13'(nbr_q[1]);
  assign bin    = {1'b0, t0_q} + 33'(nbr_q[0]);
  assign nbr_ok = !col[12] && (col[11:0] < {2'b00, w_eff})
               && !row[12] && (row[11:0] < {2'b00, h_eff})
               && (bin < 33'(n_eff));

  // Axis weights of the current neighbor
  assign wx = nbr_q[2] ? {1'b0, fx_q} : (9'd256 - {1'b0, fx_q});
  assign wy = nbr_q[1] ? {1'b0, fy_q} : (9'd256 - {1'b0, fy_q});
  assign wt = nbr_q[0] ? {1'b0, ft_q} : (25'h1000000 - {1'b0, ft_q});

  // Round to Q15.16 and add with saturation
  assign rnd   = prod_q + 42'h800000;
  assign mag   = rnd[41:24];
  assign delta = neg_q ? -33'(mag) : 33'(mag);
  assign sum   = {ram_rdata[31], ram_rdata} + delta;
  always_comb begin
    if (sum[32] != sum[31]) begin
      sat = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat = sum[31:0];
    end
  end

  assign p = 56'(dt_q) * 56'(cfg_i.bins_per_us);

  assign in_store = (32'(cell_bin_i) < MAX_BINS) && (32'(cell_row_i) < MAX_HEIGHT)
                 && (32'(cell_col_i) < MAX_WIDTH);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == ADDR_W'(CELL_COUNT - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (start_i) state_d = (command_i == CMD_READ) ? ST_RDOUT : ST_TIME;
      end
      ST_RDOUT: state_d = ST_IDLE;
      ST_TIME:  state_d = ST_NBR;
      ST_NBR: begin
        if (nbr_ok) state_d = ST_MUL;
        else if (last_nbr) state_d = ST_IDLE;
      end
      ST_MUL: state_d = ST_WR;
      ST_WR:  state_d = last_nbr ? ST_IDLE : ST_NBR;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    clr_d   = clr_q;
    ws_d    = ws_q;
    dt_d    = dt_q;
    t0_d    = t0_q;
    ft_d    = ft_q;
    nbr_d   = nbr_q;
    neg_d   = neg_q;
    x0_d    = x0_q;
    y0_d    = y0_q;
    fx_d    = fx_q;
    fy_d    = fy_q;
    wxy_d   = wxy_q;
    prod_d  = prod_q;
    addr_d  = addr_q;
    rd_ok_d = rd_ok_q;
    valid_d = 1'b0;
    value_d = value_q;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = addr_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (accept && command_i == CMD_READ) begin
          // start read of the requested cell
          addr_d    = cell_addr(BIN_W'(cell_bin_i), ROW_W'(cell_row_i), COL_W'(cell_col_i));
          rd_ok_d   = in_store;
          ram_re    = in_store;
          ram_raddr = addr_d;
        end else if (accept) begin
          // latch the event, update window start
          ws_d  = frame_start_i ? timestamp_us_i : ws_q;
          dt_d  = timestamp_us_i - ws_d;
          neg_d = !polarity_i;
          x0_d  = x_pos_i[19:8];
          y0_d  = y_pos_i[19:8];
          fx_d  = x_pos_i[7:0];
          fy_d  = y_pos_i[7:0];
        end
      end
      ST_RDOUT: begin
        // return the cell and clear it
        valid_d   = 1'b1;
        value_d   = rd_ok_q ? ram_rdata : '0;
        ram_we    = rd_ok_q;
        ram_waddr = addr_q;
      end
      ST_TIME: begin
        t0_d  = p[55:24];
        ft_d  = p[23:0];
        nbr_d = '0;
      end
      ST_NBR: begin
        addr_d    = cell_addr(bin[BIN_W-1:0], row[ROW_W-1:0], col[COL_W-1:0]);
        wxy_d     = 17'(18'(wx) * 18'(wy));
        ram_re    = nbr_ok;
        ram_raddr = addr_d;
        if (!nbr_ok) nbr_d = nbr_q + 1'b1;
      end
      ST_MUL: begin
        prod_d = 42'(wxy_q) * 42'(wt);
      end
      ST_WR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q;
        ram_wdata = sat;
        nbr_d     = nbr_q + 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      ws_q    <= '0;
      nbr_q   <= '0;
      rd_ok_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ws_q    <= ws_d;
      nbr_q   <= nbr_d;
      rd_ok_q <= rd_ok_d;
      valid_q <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dt_q    <= dt_d;
    t0_q    <= t0_d;
    ft_q    <= ft_d;
    neg_q   <= neg_d;
    x0_q    <= x0_d;
    y0_q    <= y0_d;
    fx_q    <= fx_d;
    fy_q    <= fy_d;
    wxy_q   <= wxy_d;
    prod_q  <= prod_d;
    addr_q  <= addr_d;
    value_q <= value_d;
  end

  evga_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign voxel_valid_o = valid_q;
  assign voxel_value_o = value_q;

endmodule

// File: design/event_voxel_grid_accumulator.sv
// Event voxel grid accumulator: a read command goes through the readout state and the result register to its strobe.
// An event holds busy through a time step and the read-multiply-write of each of 8 neighbors
// on one cell memory; an out-of-grid neighbor skips the multiply and the write.
// A read command holds busy through its readout state; results come as one-cycle strobes.
// After reset a clearing pass zeroes all 2097152 cells, one per cycle, with busy high.
// Registers and window start reset to their defaults at once.
module event_voxel_grid_accumulator
  import evga_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               command_i,
  input  logic signed [19:0] x_pos_i,
  input  logic signed [19:0] y_pos_i,
  input  logic [31:0]        timestamp_us_i,
  input  logic               polarity_i,
  input  logic               frame_start_i,
  input  logic [2:0]         cell_bin_i,
  input  logic [8:0]         cell_row_i,
  input  logic [8:0]         cell_col_i,
  output logic               voxel_valid_o,
  output logic signed [31:0] voxel_value_o
);

`include "event_voxel_grid_accumulator_defines.svh"

  cfg_t       cfg_q;
  logic       cfg_we;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_width  <= 10'd346;
      cfg_q.sensor_height <= 10'd260;
      cfg_q.num_bins      <= 4'd5;
      cfg_q.bins_per_us   <= 24'd671;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_SENSOR_WIDTH:  cfg_q.sensor_width  <= pwdata[9:0];
        REG_SENSOR_HEIGHT: cfg_q.sensor_height <= pwdata[9:0];
        REG_NUM_BINS:      cfg_q.num_bins      <= pwdata[3:0];
        REG_BINS_PER_US:   cfg_q.bins_per_us   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      REG_SENSOR_WIDTH:  prdata = 32'(cfg_q.sensor_width);
      REG_SENSOR_HEIGHT: prdata = 32'(cfg_q.sensor_height);
      REG_NUM_BINS:      prdata = 32'(cfg_q.num_bins);
      REG_BINS_PER_US:   prdata = 32'(cfg_q.bins_per_us);
      default:           prdata = '0;
    endcase
  end

  evga_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .start_i       (start_i),
    .command_i     (command_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .timestamp_us_i(timestamp_us_i),
    .polarity_i    (polarity_i),
    .frame_start_i (frame_start_i),
    .cell_bin_i    (cell_bin_i),
    .cell_row_i    (cell_row_i),
    .cell_col_i    (cell_col_i),
    .busy_o        (busy_o),
    .voxel_valid_o (voxel_valid_o),
    .voxel_value_o (voxel_value_o)
  );

  // A read transfer gives its result strobe after its readout state
  `EVGA_ASSERT_NEXT(a_read_result, start_i && !busy_o && command_i, !voxel_valid_o ##1 voxel_valid_o)
  // A result strobe follows a busy cycle
  `EVGA_ASSERT_IMPL(a_strobe_after_busy, voxel_valid_o, $past(busy_o))
  // Result strobes never come back to back
  `EVGA_ASSERT_IMPL(a_strobe_single, voxel_valid_o, !$past(voxel_valid_o))

endmodule
